[design/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in the same cycle implies the consequent
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies the consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/pcfs_pkg.sv]
// shared types, codes and constants of the per-channel feature scaler
package pcfs_pkg;

    localparam int MaxChannelsDefault = 16;
    localparam int FracBitsDefault    = 16;

    localparam int ModeW  = 3;
    localparam int CountW = 5;
    localparam int ValW   = 32;
    localparam int EpsW   = 31;
    localparam int IdxW   = 3;

    typedef enum logic [ModeW-1:0] {
        MODE_PASS     = 3'd0,
        MODE_MINMAX   = 3'd1,
        MODE_STANDARD = 3'd2,
        MODE_ROBUST   = 3'd3,
        MODE_MAXABS   = 3'd4
    } mode_t;

    typedef enum logic [IdxW-1:0] {
        REG_MODE       = 3'd0,
        REG_COUNT      = 3'd1,
        REG_TARGET_MIN = 3'd2,
        REG_TARGET_MAX = 3'd3,
        REG_EPSILON    = 3'd4
    } reg_index_t;

    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD  = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PREP,
        BK_DIV,
        BK_FIN
    } back_state_t;

    // sample with the statistics of its channel
    typedef struct packed {
        logic [ValW-1:0] x;
        logic [ValW-1:0] a;
        logic [ValW-1:0] b;
        logic [ValW-1:0] c;
        logic            last;
    } item_t;

    // settings the back end needs
    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [ValW-1:0]  range_lo;
        logic [ValW-1:0]  range_hi;
        logic [EpsW-1:0]  epsilon;
    } back_cfg_t;

endpackage

[design/pcfs_front.sv]
// front end: takes items, keeps the statistic tables, tracks the channel
module pcfs_front #(
    parameter int MAX_CHANNELS = pcfs_pkg::MaxChannelsDefault
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_kind,
    input  logic [3:0]                  in_channel,
    input  logic [1:0]                  in_slot,
    input  logic [pcfs_pkg::ValW-1:0]   in_value,
    input  logic                        in_last,
    input  logic [pcfs_pkg::CountW-1:0] channel_count,
    output logic                        push,
    output pcfs_pkg::item_t             push_item,
    input  logic                        queue_full
);

    localparam int PosW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CmpW = 10;

    logic [pcfs_pkg::ValW-1:0] first_mem  [MAX_CHANNELS];
    logic [pcfs_pkg::ValW-1:0] second_mem [MAX_CHANNELS];
    logic [pcfs_pkg::ValW-1:0] third_mem  [MAX_CHANNELS];

    logic [PosW-1:0]           pos_reg, pos_next;
    logic                      pend_reg, pend_next;
    logic [pcfs_pkg::ValW-1:0] x_reg;
    logic                      last_reg;
    logic [pcfs_pkg::ValW-1:0] a_reg, b_reg, c_reg;

    logic            take, take_sample, take_load, ch_ok;
    logic [CmpW-1:0] eff_count, pos_inc;
    logic [PosW-1:0] load_idx;

    assign in_ready    = !pend_reg || !queue_full;
    assign take        = in_valid && in_ready;
    assign take_sample = take && (in_kind == pcfs_pkg::KIND_SAMPLE);
    assign take_load   = take && (in_kind == pcfs_pkg::KIND_LOAD);
    assign ch_ok       = CmpW'(in_channel) < CmpW'(MAX_CHANNELS);
    assign load_idx    = PosW'(in_channel);

    always_comb
    begin
        if (channel_count == '0)
            eff_count = CmpW'(1);
        else if (CmpW'(channel_count) > CmpW'(MAX_CHANNELS))
            eff_count = CmpW'(MAX_CHANNELS);
        else
            eff_count = CmpW'(channel_count);
        pos_inc = CmpW'(pos_reg) + CmpW'(1);
        pos_next = pos_reg;
        if (take_sample)
        begin
            if (in_last || pos_inc >= eff_count)
                pos_next = '0;
            else
                pos_next = pos_inc[PosW-1:0];
        end
        pend_next = pend_reg;
        if (pend_reg && !queue_full)
            pend_next = 1'b0;
        if (take_sample)
            pend_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            pend_reg <= pend_next;
        end
    end

    // statistic tables, registered read at the current channel
    always_ff @(posedge clk)
    begin
        if (take_load && ch_ok)
        begin
            if (in_slot == pcfs_pkg::SLOT_FIRST)
                first_mem[load_idx] <= in_value;
            if (in_slot == pcfs_pkg::SLOT_SECOND)
                second_mem[load_idx] <= in_value;
            if (in_slot == pcfs_pkg::SLOT_THIRD)
                third_mem[load_idx] <= in_value;
        end
        if (take_sample)
        begin
            a_reg    <= first_mem[pos_reg];
            b_reg    <= second_mem[pos_reg];
            c_reg    <= third_mem[pos_reg];
            x_reg    <= in_value;
            last_reg <= in_last;
        end
    end

    assign push           = pend_reg && !queue_full;
    assign push_item.x    = x_reg;
    assign push_item.a    = a_reg;
    assign push_item.b    = b_reg;
    assign push_item.c    = c_reg;
    assign push_item.last = last_reg;

endmodule

[design/pcfs_queue.sv]
// two-entry queue between front and back end
module pcfs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pcfs_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output pcfs_pkg::item_t pop_item
);

    pcfs_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

[design/pcfs_back.sv]
// back end: operand setup, iterative divider, saturation, output register
module pcfs_back #(
    parameter int FRAC_BITS = pcfs_pkg::FracBitsDefault
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pcfs_pkg::back_cfg_t       cfg,
    input  logic                      q_not_empty,
    input  pcfs_pkg::item_t           q_item,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [pcfs_pkg::ValW-1:0] out_data,
    output logic                      out_last
);

    localparam int DvdW = 64;
    localparam int QCap = 40;

    typedef struct packed {
        logic [32:0] rem;
        logic [DvdW-1:0] dq;
    } div_t;

    pcfs_pkg::back_state_t state_reg, state_next;
    pcfs_pkg::item_t       item_reg;
    logic [DvdW-1:0]       dq_reg, dq_next;
    logic [32:0]           rem_reg, rem_next;
    logic [31:0]           den_reg, den_next;
    logic                  neg_reg, neg_next;
    logic [31:0]           off_reg, off_next;
    logic                  byp_reg, byp_next;
    logic [31:0]           bypv_reg, bypv_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic                  ov_reg, ov_next;
    logic [31:0]           od_reg, od_next;
    logic                  ol_reg, ol_next;

    logic signed [32:0] xs, as, bs, cs, d_xa, rng, span, den_c, ma, mb, eps_s;
    logic [32:0]        magd, mags, magx;
    logic [31:0]        magnum;
    logic [DvdW-1:0]    prod;
    div_t               s1, s2;
    logic [QCap:0]      qmag;
    logic signed [42:0] sv;
    logic [31:0]        fin_v;
    logic               out_free;

    function automatic div_t div_step(div_t cur, logic [31:0] den);
        div_t       r;
        logic [33:0] t;
        begin
            t = {cur.rem, cur.dq[DvdW-1]} - {2'b00, den};
            r.dq = {cur.dq[DvdW-2:0], !t[33]};
            r.rem = t[33] ? {cur.rem[31:0], cur.dq[DvdW-1]} : t[32:0];
            return r;
        end
    endfunction

    function automatic logic [32:0] abs33(logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    assign xs    = {item_reg.x[31], item_reg.x};
    assign as    = {item_reg.a[31], item_reg.a};
    assign bs    = {item_reg.b[31], item_reg.b};
    assign cs    = {item_reg.c[31], item_reg.c};
    assign d_xa  = xs - as;
    assign rng   = bs - as;
    assign span  = $signed({cfg.range_hi[31], cfg.range_hi})
                 - $signed({cfg.range_lo[31], cfg.range_lo});
    assign magd  = abs33(d_xa);
    assign mags  = abs33(span);
    assign magx  = abs33(xs);
    assign prod  = magd[31:0] * mags[31:0];
    assign ma    = $signed(abs33(as));
    assign mb    = $signed(abs33(bs));
    assign eps_s = $signed({2'b00, cfg.epsilon});

    assign s1 = div_step('{rem: rem_reg, dq: dq_reg}, den_reg);
    assign s2 = div_step(s1, den_reg);

    // quotient capped at 2^40, sign applied, offset added, then saturated
    assign qmag  = (dq_reg[DvdW-1:QCap] != '0) ? (QCap+1)'(1) << QCap
                                                : {1'b0, dq_reg[QCap-1:0]};
    assign sv    = (neg_reg ? -$signed(43'(qmag)) : $signed(43'(qmag)))
                 + 43'($signed(off_reg));
    assign fin_v = byp_reg ? bypv_reg
                 : (sv > 43'sd2147483647)  ? 32'h7fffffff
                 : (sv < -43'sd2147483648) ? 32'h80000000
                 : sv[31:0];

    assign out_free = !ov_reg || out_ready;
    assign q_pop    = (state_reg == pcfs_pkg::BK_IDLE) && q_not_empty;

    always_comb
    begin
        state_next = state_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        off_next   = off_reg;
        byp_next   = byp_reg;
        bypv_next  = bypv_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;
        ol_next    = ol_reg;
        den_c      = rng;
        magnum     = magd[31:0];
        unique case (state_reg)
            pcfs_pkg::BK_IDLE:
            begin
                if (q_not_empty)
                    state_next = pcfs_pkg::BK_PREP;
            end
            pcfs_pkg::BK_PREP:
            begin
                rem_next   = '0;
                cnt_next   = '0;
                off_next   = '0;
                bypv_next  = '0;
                neg_next   = d_xa[32];
                magnum     = magd[31:0];
                state_next = pcfs_pkg::BK_DIV;
                unique case (cfg.mode)
                    pcfs_pkg::MODE_MINMAX:
                    begin
                        den_c     = rng;
                        neg_next  = d_xa[32] ^ span[32];
                        off_next  = cfg.range_lo;
                        bypv_next = cfg.range_lo;
                    end
                    pcfs_pkg::MODE_STANDARD: den_c = bs;
                    pcfs_pkg::MODE_ROBUST:   den_c = cs - bs;
                    pcfs_pkg::MODE_MAXABS:
                    begin
                        den_c    = (ma > mb) ? ma : mb;
                        neg_next = xs[32];
                        magnum   = magx[31:0];
                    end
                    default: den_c = rng;
                endcase
                den_next = den_c[31:0];
                dq_next  = (cfg.mode == pcfs_pkg::MODE_MINMAX) ? prod
                         : DvdW'(magnum) << FRAC_BITS;
                // divisor at or below zero, or under epsilon, counts as zero
                byp_next = (den_c <= 0) || (den_c < eps_s);
                if (cfg.mode != pcfs_pkg::MODE_MINMAX && cfg.mode != pcfs_pkg::MODE_STANDARD
                    && cfg.mode != pcfs_pkg::MODE_ROBUST && cfg.mode != pcfs_pkg::MODE_MAXABS)
                begin
                    byp_next  = 1'b1;
                    bypv_next = item_reg.x;
                end
                if (byp_next)
                    state_next = pcfs_pkg::BK_FIN;
            end
            pcfs_pkg::BK_DIV:
            begin
                rem_next = s2.rem;
                dq_next  = s2.dq;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = pcfs_pkg::BK_FIN;
            end
            pcfs_pkg::BK_FIN:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    od_next    = fin_v;
                    ol_next    = item_reg.last;
                    state_next = pcfs_pkg::BK_IDLE;
                end
            end
            default: state_next = pcfs_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcfs_pkg::BK_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_item;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        off_reg  <= off_next;
        byp_reg  <= byp_next;
        bypv_reg <= bypv_next;
        cnt_reg  <= cnt_next;
        od_reg   <= od_next;
        ol_reg   <= ol_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_last  = ol_reg;

endmodule

[design/per_channel_feature_scaler.sv]
// top level of the per-channel feature scaler
// Scales an interleaved stream of signed fixed-point samples channel by
// channel. Load items (tuser = 1) fill three per-channel statistic tables;
// sample items (tuser = 0) are scaled by the mode register: pass-through,
// min-max, standard, robust or max-abs, and each gives one result transaction.
// A sample's result passes the front-end registers, the queue, the back
// end's item register, a setup state (subtracts and the 32x32 min-max
// product), a radix-2 restoring divider that retires two quotient bits per
// cycle over a 64-bit dividend, and a state that saturates into the output
// register. The back end takes a new sample only when idle, so the divider
// sets the throughput; pass-through and guarded samples skip it. A result
// held by the output register stalls the back end. Load items write the
// tables and give no result. The statistic tables start undefined and must
// be loaded before samples of that channel arrive.
module per_channel_feature_scaler #(
    parameter int MAX_CHANNELS = pcfs_pkg::MaxChannelsDefault,
    parameter int FRAC_BITS    = pcfs_pkg::FracBitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // stat_channel[3:0], stat_slot[5:4], value[37:6], zero pad
    input  logic        s_axis_tuser,   // kind
    input  logic        s_axis_tlast,   // last
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // scaled[31:0]
    output logic        m_axis_tlast,   // scaled_last
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration registers
    logic [pcfs_pkg::ModeW-1:0]  mode_reg;
    logic [pcfs_pkg::CountW-1:0] count_reg;
    logic [pcfs_pkg::ValW-1:0]   tmin_reg, tmax_reg;
    logic [pcfs_pkg::EpsW-1:0]   eps_reg;
    logic                        cfg_wr;

    pcfs_pkg::item_t     push_item, pop_item;
    pcfs_pkg::back_cfg_t back_cfg;
    logic                push, full, pop, not_empty;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= pcfs_pkg::MODE_PASS;
            count_reg <= 5'd1;
            tmin_reg  <= '0;
            tmax_reg  <= 32'd65536;
            eps_reg   <= 31'd1;
        end
        else if (cfg_wr)
        begin
            // indexes past the register list are dropped
            unique case (cfg_index)
                pcfs_pkg::REG_MODE:       mode_reg  <= cfg_data[pcfs_pkg::ModeW-1:0];
                pcfs_pkg::REG_COUNT:      count_reg <= cfg_data[pcfs_pkg::CountW-1:0];
                pcfs_pkg::REG_TARGET_MIN: tmin_reg  <= cfg_data;
                pcfs_pkg::REG_TARGET_MAX: tmax_reg  <= cfg_data;
                pcfs_pkg::REG_EPSILON:    eps_reg   <= cfg_data[pcfs_pkg::EpsW-1:0];
                default: ;
            endcase
        end
    end

    assign back_cfg.mode     = mode_reg;
    assign back_cfg.range_lo = tmin_reg;
    assign back_cfg.range_hi = tmax_reg;
    assign back_cfg.epsilon  = eps_reg;

    // front end: table writes and channel tracking
    pcfs_front #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_kind      (s_axis_tuser),
        .in_channel   (s_axis_tdata[3:0]),
        .in_slot      (s_axis_tdata[5:4]),
        .in_value     (s_axis_tdata[37:6]),
        .in_last      (s_axis_tlast),
        .channel_count(count_reg),
        .push         (push),
        .push_item    (push_item),
        .queue_full   (full)
    );

    // decouples the table read from the divider
    pcfs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(push_item),
        .full     (full),
        .pop      (pop),
        .not_empty(not_empty),
        .pop_item (pop_item)
    );

    // back end: arithmetic and result register
    pcfs_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (back_cfg),
        .q_not_empty(not_empty),
        .q_item     (pop_item),
        .q_pop      (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

[design/pcfs_checker.sv]
// port-level checks of the feature scaler, bound to the top level
`include "assert_macros.svh"

module pcfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `ASSERT_SAME(a_cfg_always, clk, rst_n, cfg_valid, cfg_ready)
    `ASSERT_SAME(a_in_ready_known, clk, rst_n, s_axis_tvalid, !$isunknown(s_axis_tready))

endmodule

bind per_channel_feature_scaler pcfs_checker u_pcfs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
